// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam int IN_DATA_W  = 48;  // value_in + priority_in
  localparam int OUT_DATA_W = 40;  // value_out + occupancy, padded to bytes
  localparam int OUT_USER_W = 3;   // value_valid + status

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [VAL_W-1:0]        value;
    logic signed [PRI_W-1:0] pri;
  } cell_ctl_t;

endpackage

// File: src/spq_cell.sv
// One slot of the sorted chain: holds a value and its priority.
// Depends on spq_pkg.
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_ctl_t               ctl,
  input  logic                             vld,
  input  logic                             left_take,
  input  logic [spq_pkg::VAL_W-1:0]        left_val,
  input  logic signed [spq_pkg::PRI_W-1:0] left_pri,
  input  logic [spq_pkg::VAL_W-1:0]        right_val,
  input  logic signed [spq_pkg::PRI_W-1:0] right_pri,
  output logic                             take,
  output logic [spq_pkg::VAL_W-1:0]        val,
  output logic signed [spq_pkg::PRI_W-1:0] pri
);
  import spq_pkg::*;

  logic [VAL_W-1:0]        val_r;
  logic signed [PRI_W-1:0] pri_r;

  // Empty slots and strictly larger priorities make room; equal ones stay (FIFO ties).
  assign take = !vld || ($signed(pri_r) > $signed(ctl.pri));
  assign val  = val_r;
  assign pri  = pri_r;

  always_ff @(posedge clk) begin
    if (ctl.rem) begin
      val_r <= right_val;
      pri_r <= right_pri;
    end else if (ctl.ins && take) begin
      if (left_take) begin
        val_r <= left_val;
        pri_r <= left_pri;
      end else begin
        val_r <= ctl.value;
        pri_r <= ctl.pri;
      end
    end
  end

endmodule

// File: src/sorted_priority_queue.sv
// Sorted priority queue: a chain of CAPACITY cells kept in ascending priority order.
// The result beat is registered and presented in the cycle after its input beat is accepted.
// One insert or remove per cycle while the output is not stalled; every cell compares in
// parallel and the whole chain shifts at once.
// Reset clears the entry count and the output valid; the slots need no clearing.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]      in_tdata,   // value_in[31:0], priority_in[47:32]
  input  logic                               in_tuser,   // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]     out_tdata,  // value_out[31:0], occupancy[36:32]
  output logic [spq_pkg::OUT_USER_W-1:0]     out_tuser   // value_valid[0], status[2:1]
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r;
  logic [VAL_W-1:0] oval_r;
  logic             ovv_r;
  status_t          ostat_r;
  logic [OCC_W-1:0] oocc_r;

  logic             acc, is_ins, full, empty;
  cell_ctl_t        ctl;
  status_t          stat_nxt;

  logic [CAPACITY-1:0]     cell_vld;
  logic [CAPACITY-1:0]     take_w;
  logic [VAL_W-1:0]        val_w [CAPACITY];
  logic signed [PRI_W-1:0] pri_w [CAPACITY];

  assign in_tready = !ovld_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_ins    = (cmd_t'(in_tuser) == CMD_INSERT);
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  always_comb begin
    ctl.ins   = acc && is_ins && !full;
    ctl.rem   = acc && !is_ins && !empty;
    ctl.value = in_tdata[VAL_W-1:0];
    ctl.pri   = in_tdata[VAL_W +: PRI_W];
    cnt_nxt   = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    stat_nxt = ST_OK;
    if (acc && is_ins && full) begin
      stat_nxt = ST_FULL;
    end else if (acc && !is_ins && empty) begin
      stat_nxt = ST_EMPTY;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    lt;
    logic [VAL_W-1:0]        lv, rv;
    logic signed [PRI_W-1:0] lp, rp;

    assign cell_vld[g] = (cnt_r > CNT_W'(g));

    if (g == 0) begin : g_head
      assign lt = 1'b0;
      assign lv = '0;
      assign lp = '0;
    end else begin : g_mid
      assign lt = take_w[g-1];
      assign lv = val_w[g-1];
      assign lp = pri_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rv = val_w[g];
      assign rp = pri_w[g];
    end else begin : g_body
      assign rv = val_w[g+1];
      assign rp = pri_w[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .vld       (cell_vld[g]),
      .left_take (lt),
      .left_val  (lv),
      .left_pri  (lp),
      .right_val (rv),
      .right_pri (rp),
      .take      (take_w[g]),
      .val       (val_w[g]),
      .pri       (pri_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        ovld_r <= 1'b1;
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      oval_r  <= ctl.rem ? val_w[0] : '0;
      ovv_r   <= ctl.rem;
      ostat_r <= stat_nxt;
      oocc_r  <= OCC_W'(cnt_nxt);
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - OCC_W){1'b0}}, oocc_r, oval_r};
  assign out_tuser  = {ostat_r, ovv_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ovv_r) |-> (ostat_r == ST_OK))
    else $error("removed value reported with error status");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ostat_r == ST_EMPTY) |-> (oocc_r == '0 && !ovv_r))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ostat_r == ST_FULL) |-> (oocc_r == OCC_W'(CAPACITY)))
    else $error("full status without full occupancy");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("remove did not decrement count");

endmodule
